// File: hdl/rwd_pkg.sv
// Shared types and constants for the raster work dispenser.
package rwd_pkg;

  localparam int MaxWidth  = 128;
  localparam int MaxHeight = 128;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;
  localparam int Cells = MaxWidth * MaxHeight;
  localparam logic [35:0] CountMax = '1;
  localparam logic [13:0] Scale = 14'd10000;

  // Stored count: whole part and fraction in units of 1/10000.
  localparam int WholeW = 23;
  localparam int FracW  = 14;
  localparam int CountW = WholeW + FracW;
  localparam logic [WholeW-1:0] SatWhole = 23'd6871947;
  localparam logic [FracW-1:0]  SatFrac  = 14'd6735;

  localparam logic [1:0] CMD_FETCH  = 2'd0;
  localparam logic [1:0] CMD_SAVE   = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  point_x;
    logic [6:0]  point_y;
    logic [19:0] iteration_count;
    logic [63:0] z_word0;
    logic [63:0] z_word1;
    logic [63:0] z_word2;
    logic [63:0] z_word3;
    logic        done_flag;
    logic [15:0] escape_velocity;
  } request_t;

  typedef struct packed {
    logic        found;
    logic [6:0]  found_x;
    logic [6:0]  found_y;
    logic [22:0] pending_count;
    logic [63:0] out_z0;
    logic [63:0] out_z1;
    logic [63:0] out_z2;
    logic [63:0] out_z3;
    logic        scan_completed;
  } result_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [1:0]    command;
    logic          in_raster;
    logic [AW-1:0] addr;
    logic [19:0]   save_count;
    logic [13:0]   add;
    logic [255:0]  z;
    logic          done_flag;
  } work_t;

  // Effective size: zero counts as one, capped at the limit.
  function automatic logic [7:0] eff_size(input logic [7:0] v, input int unsigned limit);
    logic [8:0] lim;
    lim = (limit > 128) ? 9'd128 : 9'(limit);
    if (v == 8'd0) return 8'd1;
    if ({1'b0, v} > lim) return lim[7:0];
    return v;
  endfunction

endpackage

// File: hdl/rwd_front.sv
// Front end: accept requests, classify them and precompute save and update values.
module rwd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rwd_pkg::request_t req,
  input  logic [7:0]        width_eff,
  input  logic [7:0]        height_eff,
  output logic              work_valid,
  input  logic              work_take,
  output rwd_pkg::work_t    work
);
  import rwd_pkg::*;

  logic [29:0] mul_ev;
  logic        in_raster;

  assign full = work_valid && !work_take;
  assign in_raster = ({1'b0, req.point_x} < width_eff) && ({1'b0, req.point_y} < height_eff);
  assign mul_ev = 30'(req.escape_velocity) * 30'(Scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (push && !full) begin
      work_valid <= 1'b1;
    end else if (work_take) begin
      work_valid <= 1'b0;
    end
    if (push && !full) begin
      work.command <= req.command;
      work.in_raster <= in_raster;
      work.addr <= {req.point_y[YW-1:0], req.point_x[XW-1:0]};
      work.save_count <= req.iteration_count;
      work.add <= mul_ev[29:16];
      work.z <= {req.z_word3, req.z_word2, req.z_word1, req.z_word0};
      work.done_flag <= req.done_flag;
    end
  end

endmodule

// File: hdl/rwd_back.sv
// Back end: point tables, cursor scan and result register.
module rwd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              work_valid,
  output logic              work_take,
  input  rwd_pkg::work_t    work,
  input  logic [7:0]        width_eff,
  input  logic [7:0]        height_eff,
  input  logic [19:0]       target,
  output logic              empty,
  input  logic              pop,
  output rwd_pkg::result_t  res,
  output logic              busy
);
  import rwd_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPDATE, S_SCAN} state_t;

  logic [CountW-1:0] count_mem [Cells];
  logic              fin_mem   [Cells];
  logic [255:0]      z_mem     [Cells];

  state_t            state;
  logic [AW-1:0]     clr;
  logic [6:0]        cursor_x, cursor_y;
  logic [6:0]        cursor_x_next, cursor_y_next;
  logic              completed, completed_next;
  work_t             cur;
  logic [AW-1:0]     raddr;
  logic [CountW-1:0] rd_count;
  logic              rd_fin;
  logic [255:0]      rd_z;
  logic [WholeW-1:0] rd_whole;
  logic [FracW-1:0]  rd_frac;
  logic [FracW:0]    frac_sum;
  logic [FracW:0]    frac_wrap;
  logic              carry;
  logic [FracW-1:0]  frac_new;
  logic [WholeW-1:0] whole_new;
  logic              sat;
  logic [CountW-1:0] upd_count;
  logic              in_range;
  logic              last_col, last_row;
  logic              hit;
  result_t           res_next;

  assign rd_whole = rd_count[CountW-1:FracW];
  assign rd_frac = rd_count[FracW-1:0];
  assign frac_sum = {1'b0, rd_frac} + {1'b0, cur.add};
  assign frac_wrap = frac_sum - {1'b0, Scale};
  assign carry = frac_sum >= {1'b0, Scale};
  assign frac_new = carry ? frac_wrap[FracW-1:0] : frac_sum[FracW-1:0];
  assign whole_new = rd_whole + {{(WholeW-1){1'b0}}, carry};
  assign sat = (whole_new > SatWhole) || ((whole_new == SatWhole) && (frac_new > SatFrac));
  assign upd_count = sat ? {SatWhole, SatFrac} : {whole_new, frac_new};

  assign in_range = ({1'b0, cursor_x} < width_eff) && ({1'b0, cursor_y} < height_eff);
  assign last_col = ({1'b0, cursor_x} + 8'd1) >= width_eff;
  assign last_row = ({1'b0, cursor_y} + 8'd1) >= height_eff;
  assign hit = in_range && !rd_fin && (rd_whole < {3'd0, target});
  assign work_take = (state == S_IDLE) && work_valid && empty;
  assign busy = (state != S_IDLE) || !empty || work_valid;

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    completed_next = completed;
    if (last_col) begin
      if (last_row) begin
        completed_next = 1'b1;
      end else begin
        cursor_x_next = '0;
        cursor_y_next = cursor_y + 7'd1;
      end
    end else begin
      cursor_x_next = cursor_x + 7'd1;
    end
  end

  always_comb begin
    if (state == S_IDLE) begin
      raddr = (work.command == CMD_FETCH) ? {cursor_y[YW-1:0], cursor_x[XW-1:0]} : work.addr;
    end else begin
      raddr = {cursor_y_next[YW-1:0], cursor_x_next[XW-1:0]};
    end
  end

  always_comb begin
    res_next = '0;
    res_next.scan_completed = completed;
    if (state == S_IDLE) begin
      res_next.found = (work.command == CMD_SAVE);
    end else if (state == S_UPDATE) begin
      res_next.found = 1'b1;
    end else if (state == S_SCAN) begin
      res_next.scan_completed = completed_next;
      if (hit) begin
        res_next.found = 1'b1;
        res_next.found_x = cursor_x;
        res_next.found_y = cursor_y;
        res_next.pending_count = rd_whole;
        res_next.out_z0 = rd_z[63:0];
        res_next.out_z1 = rd_z[127:64];
        res_next.out_z2 = rd_z[191:128];
        res_next.out_z3 = rd_z[255:192];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_count <= count_mem[raddr];
    rd_fin   <= fin_mem[raddr];
    rd_z     <= z_mem[raddr];
    if (state == S_CLEAR) begin
      count_mem[clr] <= '0;
      fin_mem[clr] <= 1'b0;
      z_mem[clr] <= '0;
    end else if (work_take && work.in_raster && work.command == CMD_SAVE) begin
      count_mem[work.addr] <= {3'd0, work.save_count, {FracW{1'b0}}};
      fin_mem[work.addr] <= work.done_flag;
      z_mem[work.addr] <= work.z;
    end else if (state == S_UPDATE && cur.in_raster) begin
      count_mem[cur.addr] <= upd_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      cursor_x <= '0;
      cursor_y <= '0;
      completed <= 1'b0;
      empty <= 1'b1;
    end else if (!empty) begin
      if (pop) empty <= 1'b1;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (work_take) begin
            cur <= work;
            case (work.command)
              CMD_FETCH: begin
                if (completed) begin
                  res <= res_next;
                  empty <= 1'b0;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_UPDATE: state <= S_UPDATE;
              default: begin
                res <= res_next;
                empty <= 1'b0;
              end
            endcase
          end
        end
        S_UPDATE: begin
          res <= res_next;
          empty <= 1'b0;
          state <= S_IDLE;
        end
        S_SCAN: begin
          cursor_x <= cursor_x_next;
          cursor_y <= cursor_y_next;
          completed <= completed_next;
          if (hit || completed_next) begin
            res <= res_next;
            empty <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/raster_work_dispenser.sv
// Raster work dispenser top level.
// Requests wait in a one-entry front register and reach the point table one at a time;
// the next request is taken only once the previous result has been popped. Counted from
// the edge that takes a request from the front register, a save or an unused command has
// its result ready after that same edge and an update in the following cycle (read, then
// write back). A fetch steps the scan through the points, pending or skipped, until it
// finds a pending point or completes, so its time depends on the table contents; a fetch
// after the scan has completed answers at once. The take itself comes on a later edge
// than the one that accepts the request. After reset a clearing pass over all 16384
// table cells runs before the first request is taken.
module raster_work_dispenser (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rwd_pkg::request_t req,
  output logic              empty,
  input  logic              pop,
  output rwd_pkg::result_t  res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [19:0]       cfg_data
);
  import rwd_pkg::*;

  logic [7:0]  raster_width, raster_height;
  logic [19:0] target_iterations;
  logic [7:0]  w_eff, h_eff;
  logic        work_valid, work_take, busy;
  work_t       work;

  assign w_eff = eff_size(raster_width, MaxWidth);
  assign h_eff = eff_size(raster_height, MaxHeight);

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_width <= 8'd128;
      raster_height <= 8'd128;
      target_iterations <= 20'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  raster_width <= cfg_data[7:0];
        REG_HEIGHT: raster_height <= cfg_data[7:0];
        REG_TARGET: target_iterations <= cfg_data;
        default: ;
      endcase
    end
  end

  rwd_front u_front (
    .clk, .rst, .push, .full, .req,
    .width_eff(w_eff), .height_eff(h_eff),
    .work_valid, .work_take, .work
  );

  rwd_back u_back (
    .clk, .rst, .work_valid, .work_take, .work,
    .width_eff(w_eff), .height_eff(h_eff), .target(target_iterations),
    .empty, .pop, .res, .busy
  );

`ifndef SYNTHESIS
  a_take_needs_valid: assert property (@(posedge clk) disable iff (rst)
    work_take |-> work_valid) else $error("take without work");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !empty |-> busy) else $error("busy low with result");
`endif

endmodule
